[hdl/nmrl_pkg.sv]
// Package for the NDEF MIME record locator: widths, byte codes, the type string,
// parser phase and verdict types, and the structs passed between the stages.
// No dependencies.
`default_nettype none

package nmrl_pkg;

  // Byte counter width and the length of the MIME type string.
  localparam int COUNT_WIDTH     = 16;
  localparam int TYPE_STRING_LEN = 21;

  // Message end and skip counters must hold a count plus a 16-bit TLV length.
  localparam int ME_W = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 1;

  localparam logic [COUNT_WIDTH-1:0] MAX_COUNT = '1;

  // TLV and capability container codes.
  localparam logic [7:0] CC_MAGIC = 8'hE1;
  localparam logic [7:0] TLV_NULL = 8'h00;
  localparam logic [7:0] TLV_NDEF = 8'h03;
  localparam logic [7:0] TLV_TERM = 8'hFE;
  localparam logic [7:0] LEN_ESC  = 8'hFF;
  localparam logic [7:0] CC_SKIP  = 8'h03;

  // Record header bits.
  localparam int HDR_CF = 5;
  localparam int HDR_SR = 4;
  localparam int HDR_IL = 3;
  localparam logic [2:0] TNF_MIME = 3'd2;

  // Bit positions in the record flag register.
  localparam int F_SR   = 0;
  localparam int F_IL   = 1;
  localparam int F_MIME = 2;
  localparam int F_NDEF = 3;

  // Expected MIME type, byte 0 in the low bits; the unused tail reads as zero.
  localparam logic [32*8-1:0] TYPE_TEXT = {88'h0,
    8'h64, 8'h33, 8'h67, 8'h61, 8'h74, 8'h6E, 8'h65, 8'h70, 8'h6F, 8'h2F, 8'h6E,
    8'h6F, 8'h69, 8'h74, 8'h61, 8'h63, 8'h69, 8'h6C, 8'h70, 8'h70, 8'h61};

  typedef enum logic [3:0] {
    PH_FIRST,
    PH_CC,
    PH_TLV_TYPE,
    PH_TLV_LEN,
    PH_TLV_EXT,
    PH_TLV_SKIP,
    PH_REC_HDR,
    PH_REC_TLEN,
    PH_REC_PLEN,
    PH_REC_IDLEN,
    PH_REC_TYPE,
    PH_REC_ID,
    PH_REC_PAYLOAD
  } phase_t;

  typedef enum logic [1:0] {
    V_UNDECIDED,
    V_NONE,
    V_PENDING,
    V_FOUND
  } verdict_t;

  typedef struct packed {
    logic [7:0] tag_byte;
    logic       end_of_dump;
  } byte_t;

  typedef struct packed {
    logic        found;
    logic [15:0] payload_offset;
    logic [15:0] payload_length;
  } result_t;

endpackage

`default_nettype wire

[hdl/nmrl_if.sv]
// Valid/ready channel interfaces for the tag byte input and the result output.
// No dependencies.
`default_nettype none

interface nmrl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] tag_byte;
  logic       end_of_dump;

  modport source (output valid, output tag_byte, output end_of_dump, input ready);
  modport sink (input valid, input tag_byte, input end_of_dump, output ready);
endinterface

interface nmrl_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [15:0] payload_offset;
  logic [15:0] payload_length;

  modport source (output valid, output found, output payload_offset,
                  output payload_length, input ready);
  modport sink (input valid, input found, input payload_offset,
                input payload_length, output ready);
endinterface

`default_nettype wire

[hdl/ndef_mime_record_locator_top.sv]
// NDEF MIME record locator: scans a raw NFC tag memory dump for the first MIME
// record of the expected type and reports where its payload lies.
// Depends on nmrl_pkg, nmrl_if, nmrl_in_reg, nmrl_parser and nmrl_out_reg.
//
// in_ch carries one tag memory byte per word, with end_of_dump set on the final
// byte. out_ch carries exactly one word per dump, after its final byte: found,
// and the payload offset and length (both zero when nothing was found).
// Throughput is one byte per cycle: the parser makes one state update per byte
// between the input register and the result register. A dump's final byte is
// registered in the input register and its result in the result register.
// If the result register is still full, bytes keep flowing; only the final byte
// of the next dump waits in the input register until the result is taken.
// Synchronous reset clears the parser and both registers; the
// block then expects the first byte of a dump. After each final byte it returns
// to the same start state by itself.
`default_nettype none

module ndef_mime_record_locator_top (
  input  wire logic   clk,
  input  wire logic   rst_n,
  nmrl_in_if.sink     in_ch,
  nmrl_out_if.source  out_ch
);
  import nmrl_pkg::*;

  logic    byte_valid;
  byte_t   byte_q;
  logic    take;
  logic    res_valid;
  result_t res;
  logic    res_room;

  nmrl_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (take),
    .byte_valid (byte_valid),
    .byte_q     (byte_q)
  );

  nmrl_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_i     (byte_q),
    .res_room   (res_room),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  nmrl_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_room  (res_room),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

[hdl/nmrl_in_reg.sv]
// Input register of the locator: holds one tag byte until the parser takes it.
// Depends on nmrl_pkg and nmrl_in_if.
`default_nettype none

module nmrl_in_reg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  nmrl_in_if.sink            in_ch,
  input  wire logic          take,
  output logic               byte_valid,
  output nmrl_pkg::byte_t    byte_q
);
  import nmrl_pkg::*;

  logic  valid_r;
  byte_t data_r;

  assign in_ch.ready = !valid_r || take;
  assign byte_valid  = valid_r;
  assign byte_q      = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      data_r.tag_byte    <= in_ch.tag_byte;
      data_r.end_of_dump <= in_ch.end_of_dump;
    end
  end

endmodule

`default_nettype wire

[hdl/nmrl_parser.sv]
// Byte-wise TLV and NDEF record parser: one state update per tag byte, and the
// verdict for the dump on its final byte. Depends on nmrl_pkg.
`default_nettype none

module nmrl_parser (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          byte_valid,
  input  wire nmrl_pkg::byte_t byte_i,
  input  wire logic          res_room,
  output logic               take,
  output logic               res_valid,
  output nmrl_pkg::result_t  res
);
  import nmrl_pkg::*;

  phase_t                 phase_r, phase_nxt;
  verdict_t               verdict_r, verdict_nxt, verdict_fin;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic [ME_W-1:0]        msg_end_r, msg_end_nxt;
  logic [ME_W-1:0]        skip_r, skip_nxt;
  logic [31:0]            len_acc_r, len_acc_nxt;
  logic [3:0]             flags_r, flags_nxt;
  logic [7:0]             tlen_r, tlen_nxt;
  logic [7:0]             idlen_r, idlen_nxt;
  logic [4:0]             tidx_r, tidx_nxt;
  logic                   mism_r, mism_nxt;
  logic [COUNT_WIDTH-1:0] moff_r, moff_nxt, moff_fin;
  logic [15:0]            mlen_r, mlen_nxt, mlen_fin;

  logic [7:0]             b;
  logic                   last;
  logic [COUNT_WIDTH-1:0] q;
  logic [ME_W-1:0]        qx;
  logic [ME_W-1:0]        skip_dec;
  logic [4:0]             tidx_dec;
  logic [7:0]             tlen_dec;
  logic [7:0]             idlen_dec;
  logic [31:0]            la_shift;
  logic [15:0]            tlv_len;
  logic [31:0]            al_la;
  logic [7:0]             al_il;
  logic [ME_W-1:0]        room;
  logic [32:0]            need;
  logic                   al_fail;
  logic                   al_mism;
  logic [7:0]             text_byte;
  logic                   type_mism;
  logic                   ep_m;
  logic [31:0]            ep_la;
  logic                   do_tld;
  logic                   do_al;
  logic                   do_enter;

  assign b    = byte_i.tag_byte;
  assign last = byte_i.end_of_dump;
  // A final byte needs space in the result register; others never wait.
  assign take = byte_valid && (!last || res_room);

  assign q         = count_r + 1'b1;
  assign qx        = ME_W'(q);
  assign skip_dec  = (skip_r != '0) ? skip_r - 1'b1 : '0;
  assign tidx_dec  = (tidx_r != '0) ? tidx_r - 1'b1 : '0;
  assign tlen_dec  = (tlen_r != '0) ? tlen_r - 1'b1 : '0;
  assign idlen_dec = (idlen_r != '0) ? idlen_r - 1'b1 : '0;
  assign la_shift  = {len_acc_r[23:0], b};
  assign tlv_len   = (phase_r == PH_TLV_EXT) ? {len_acc_r[7:0], b} : {8'h00, b};

  // Bounds check once all record lengths are known: type, ID and payload must
  // fit between the current position and the end of the NDEF TLV.
  assign al_la   = (phase_r == PH_REC_PLEN) ? la_shift : len_acc_r;
  assign al_il   = (phase_r == PH_REC_IDLEN) ? b : 8'h00;
  assign room    = msg_end_r - qx;
  assign need    = 33'(al_la) + 33'(tlen_r) + 33'(al_il);
  assign al_fail = (qx > msg_end_r) || (need > 33'(room));
  assign al_mism = !(flags_r[F_MIME] && (tlen_r == 8'(TYPE_STRING_LEN)));

  assign text_byte = TYPE_TEXT[{tidx_r, 3'b000} +: 8];
  assign type_mism = mism_r || (b != text_byte);

  always_comb begin
    case (phase_r)
      PH_REC_PLEN, PH_REC_IDLEN: ep_m = al_mism;
      PH_REC_TYPE:               ep_m = type_mism;
      default:                   ep_m = mism_r;
    endcase
    ep_la = al_la;
  end

  // Next state.
  always_comb begin
    phase_nxt   = phase_r;
    verdict_nxt = verdict_r;
    count_nxt   = count_r;
    msg_end_nxt = msg_end_r;
    skip_nxt    = skip_r;
    len_acc_nxt = len_acc_r;
    flags_nxt   = flags_r;
    tlen_nxt    = tlen_r;
    idlen_nxt   = idlen_r;
    tidx_nxt    = tidx_r;
    mism_nxt    = mism_r;
    moff_nxt    = moff_r;
    mlen_nxt    = mlen_r;
    do_tld      = 1'b0;
    do_al       = 1'b0;
    do_enter    = 1'b0;

    if (take && ((verdict_r == V_UNDECIDED) || (verdict_r == V_PENDING))) begin
      if (count_r == MAX_COUNT) begin
        verdict_nxt = V_NONE;
      end else begin
        count_nxt = q;
        if (verdict_r == V_UNDECIDED) begin
          case (phase_r)
            PH_FIRST: begin
              if (b == CC_MAGIC) begin
                skip_nxt  = ME_W'(CC_SKIP);
                phase_nxt = PH_CC;
              end else if (b == TLV_NULL) begin
                phase_nxt = PH_TLV_TYPE;
              end else if (b == TLV_TERM) begin
                verdict_nxt = V_NONE;
              end else begin
                flags_nxt = '0;
                flags_nxt[F_NDEF] = (b == TLV_NDEF);
                phase_nxt = PH_TLV_LEN;
              end
            end
            PH_CC, PH_TLV_SKIP: begin
              skip_nxt = skip_dec;
              if (skip_dec == '0) begin
                phase_nxt = PH_TLV_TYPE;
              end
            end
            PH_TLV_TYPE: begin
              if (b == TLV_NULL) begin
                phase_nxt = PH_TLV_TYPE;
              end else if (b == TLV_TERM) begin
                verdict_nxt = V_NONE;
              end else begin
                flags_nxt = '0;
                flags_nxt[F_NDEF] = (b == TLV_NDEF);
                phase_nxt = PH_TLV_LEN;
              end
            end
            PH_TLV_LEN: begin
              if (b == LEN_ESC) begin
                len_acc_nxt = '0;
                tidx_nxt    = 5'd2;
                phase_nxt   = PH_TLV_EXT;
              end else begin
                do_tld = 1'b1;
              end
            end
            PH_TLV_EXT: begin
              len_acc_nxt = {16'h0000, tlv_len};
              tidx_nxt    = tidx_dec;
              do_tld      = (tidx_dec == '0);
            end
            PH_REC_HDR: begin
              if (b[HDR_CF] || (qx >= msg_end_r)) begin
                verdict_nxt = V_NONE;
              end else begin
                flags_nxt         = '0;
                flags_nxt[F_SR]   = b[HDR_SR];
                flags_nxt[F_IL]   = b[HDR_IL];
                flags_nxt[F_MIME] = (b[2:0] == TNF_MIME);
                phase_nxt         = PH_REC_TLEN;
              end
            end
            PH_REC_TLEN: begin
              tlen_nxt    = b;
              len_acc_nxt = '0;
              if (flags_r[F_SR]) begin
                if (qx >= msg_end_r) begin
                  verdict_nxt = V_NONE;
                end else begin
                  tidx_nxt  = 5'd1;
                  phase_nxt = PH_REC_PLEN;
                end
              end else if ((qx + ME_W'(4)) > msg_end_r) begin
                verdict_nxt = V_NONE;
              end else begin
                tidx_nxt  = 5'd4;
                phase_nxt = PH_REC_PLEN;
              end
            end
            PH_REC_PLEN: begin
              len_acc_nxt = la_shift;
              tidx_nxt    = tidx_dec;
              if (tidx_dec == '0) begin
                if (flags_r[F_IL]) begin
                  if (qx >= msg_end_r) begin
                    verdict_nxt = V_NONE;
                  end else begin
                    phase_nxt = PH_REC_IDLEN;
                  end
                end else begin
                  idlen_nxt = '0;
                  do_al     = 1'b1;
                end
              end
            end
            PH_REC_IDLEN: begin
              idlen_nxt = b;
              do_al     = 1'b1;
            end
            PH_REC_TYPE: begin
              mism_nxt = type_mism;
              tidx_nxt = tidx_r + 1'b1;
              tlen_nxt = tlen_dec;
              if (tlen_dec == '0) begin
                if (idlen_r != '0) begin
                  phase_nxt = PH_REC_ID;
                end else begin
                  do_enter = 1'b1;
                end
              end
            end
            PH_REC_ID: begin
              idlen_nxt = idlen_dec;
              do_enter  = (idlen_dec == '0);
            end
            PH_REC_PAYLOAD: begin
              skip_nxt = skip_dec;
              if (skip_dec == '0) begin
                if (qx < msg_end_r) begin
                  phase_nxt = PH_REC_HDR;
                end else begin
                  verdict_nxt = V_NONE;
                end
              end
            end
            default: begin
              verdict_nxt = V_NONE;
            end
          endcase

          // TLV length complete.
          if (do_tld) begin
            if (flags_r[F_NDEF]) begin
              if (tlv_len == '0) begin
                verdict_nxt = V_NONE;
              end else begin
                msg_end_nxt = qx + ME_W'(tlv_len);
                phase_nxt   = PH_REC_HDR;
              end
            end else if (tlv_len == '0) begin
              phase_nxt = PH_TLV_TYPE;
            end else begin
              skip_nxt  = ME_W'(tlv_len);
              phase_nxt = PH_TLV_SKIP;
            end
          end

          // All record lengths known.
          if (do_al) begin
            if (al_fail) begin
              verdict_nxt = V_NONE;
            end else begin
              mism_nxt = al_mism;
              tidx_nxt = '0;
              if (tlen_r != '0) begin
                phase_nxt = PH_REC_TYPE;
              end else if (al_il != '0) begin
                phase_nxt = PH_REC_ID;
              end else begin
                do_enter = 1'b1;
              end
            end
          end

          // Start of a payload: the match, a payload to step over, or on to the next header.
          if (do_enter) begin
            if (!ep_m) begin
              moff_nxt    = q;
              mlen_nxt    = ep_la[15:0];
              verdict_nxt = V_PENDING;
            end else if (ep_la != '0) begin
              skip_nxt  = ep_la[ME_W-1:0];
              phase_nxt = PH_REC_PAYLOAD;
            end else if (qx < msg_end_r) begin
              phase_nxt = PH_REC_HDR;
            end else begin
              verdict_nxt = V_NONE;
            end
          end
        end

        // A match counts only once its whole NDEF TLV has been seen.
        if ((verdict_nxt == V_PENDING) && (qx >= msg_end_nxt)) begin
          verdict_nxt = V_FOUND;
        end
      end
    end

    verdict_fin = verdict_nxt;
    moff_fin    = moff_nxt;
    mlen_fin    = mlen_nxt;

    if (take && last) begin
      phase_nxt   = PH_FIRST;
      verdict_nxt = V_UNDECIDED;
      count_nxt   = '0;
      msg_end_nxt = '0;
      skip_nxt    = '0;
      len_acc_nxt = '0;
      flags_nxt   = '0;
      tlen_nxt    = '0;
      idlen_nxt   = '0;
      tidx_nxt    = '0;
      mism_nxt    = 1'b0;
      moff_nxt    = '0;
      mlen_nxt    = '0;
    end
  end

  // Result of a dump.
  always_comb begin
    res_valid = take && last;
    res.found = (verdict_fin == V_FOUND);
    if (verdict_fin == V_FOUND) begin
      res.payload_offset = 16'(moff_fin);
      res.payload_length = mlen_fin;
    end else begin
      res.payload_offset = '0;
      res.payload_length = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_FIRST;
      verdict_r <= V_UNDECIDED;
      count_r   <= '0;
      msg_end_r <= '0;
      skip_r    <= '0;
      len_acc_r <= '0;
      flags_r   <= '0;
      tlen_r    <= '0;
      idlen_r   <= '0;
      tidx_r    <= '0;
      mism_r    <= 1'b0;
      moff_r    <= '0;
      mlen_r    <= '0;
    end else begin
      phase_r   <= phase_nxt;
      verdict_r <= verdict_nxt;
      count_r   <= count_nxt;
      msg_end_r <= msg_end_nxt;
      skip_r    <= skip_nxt;
      len_acc_r <= len_acc_nxt;
      flags_r   <= flags_nxt;
      tlen_r    <= tlen_nxt;
      idlen_r   <= idlen_nxt;
      tidx_r    <= tidx_nxt;
      mism_r    <= mism_nxt;
      moff_r    <= moff_nxt;
      mlen_r    <= mlen_nxt;
    end
  end

  a_dump_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    take && last |=> (verdict_r == V_UNDECIDED) && (phase_r == PH_FIRST) &&
                     (count_r == '0))
    else $error("parser did not return to its start state after the final word");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !take |=> $stable(count_r) && $stable(verdict_r) && $stable(phase_r))
    else $error("parser state moved without a word being taken");

  a_found_complete: assert property (@(posedge clk) disable iff (!rst_n)
    (verdict_r == V_FOUND) |-> (ME_W'(count_r) >= msg_end_r))
    else $error("match reported before the end of its NDEF TLV");

endmodule

`default_nettype wire

[hdl/nmrl_out_reg.sv]
// Result register of the locator: holds one result word until the sink takes it.
// Depends on nmrl_pkg and nmrl_out_if.
`default_nettype none

module nmrl_out_reg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          res_valid,
  input  wire nmrl_pkg::result_t res,
  output logic               res_room,
  nmrl_out_if.source         out_ch
);
  import nmrl_pkg::*;

  logic    valid_r;
  result_t data_r;

  assign res_room              = !valid_r || out_ch.ready;
  assign out_ch.valid          = valid_r;
  assign out_ch.found          = data_r.found;
  assign out_ch.payload_offset = data_r.payload_offset;
  assign out_ch.payload_length = data_r.payload_length;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_valid) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      data_r <= res;
    end
  end

endmodule

`default_nettype wire
